[rtl/lbg_pkg.sv]
// ----------------------------------------------------------------------------
// lbg_pkg
// shared widths, reset values and codes of the bump-and-go controller
// ----------------------------------------------------------------------------
package lbg_pkg;

  localparam int unsigned RANGE_W     = 16;
  localparam int unsigned FRONT_IDX_W = 11;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned CODE_W      = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned MAX_SAMPLES_DEF = 2048;

  // item kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // motion codes
  typedef enum logic [CODE_W-1:0] {
    MOVE_FORWARD = 2'd0,
    MOVE_REVERSE = 2'd1,
    MOVE_TURN    = 2'd2
  } motion_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBSTACLE_DIST = 3'd0,
    CFG_FRONT_FIRST   = 3'd1,
    CFG_FRONT_LAST    = 3'd2,
    CFG_RANGE_MIN     = 3'd3,
    CFG_RANGE_MAX     = 3'd4,
    CFG_BACKING_TICKS = 3'd5,
    CFG_TURNING_TICKS = 3'd6
  } cfg_idx_t;

  // register reset values
  localparam logic [RANGE_W-1:0]     OBSTACLE_DIST_RST = 16'd500;
  localparam logic [FRONT_IDX_W-1:0] FRONT_FIRST_RST   = 11'd0;
  localparam logic [FRONT_IDX_W-1:0] FRONT_LAST_RST    = 11'd2047;
  localparam logic [RANGE_W-1:0]     RANGE_MIN_RST     = 16'd0;
  localparam logic [RANGE_W-1:0]     RANGE_MAX_RST     = 16'd65535;
  localparam logic [TICK_W-1:0]      BACKING_TICKS_RST = 16'd2000;
  localparam logic [TICK_W-1:0]      TURNING_TICKS_RST = 16'd2000;

  localparam logic [TICK_W-1:0]      TICK_SAT = {TICK_W{1'b1}};

endpackage

[rtl/lidar_bump_and_go_controller.sv]
// ----------------------------------------------------------------------------
// lidar_bump_and_go_controller
// bump-and-go obstacle avoidance driven by a lidar range stream
// ----------------------------------------------------------------------------
// Requests are range samples of a lidar scan (one per request) and time ticks.
// Over each scan the block keeps the least valid range whose sample index falls
// in the front window; a range is valid when marked finite and inside the
// configured lower and upper range limits. On the last sample of a scan that
// saw a valid front range, a drive / back-up / turn machine is stepped and one
// result request carries the motion code, the new mode and the front minimum.
// Scans without a valid front sample, and ticks, give no result. The block
// takes one request per cycle: each request sits in an input register while
// a compare and minimum update run, and results land in an output register,
// so the input side keeps flowing while a result waits; the only stall is
// when a scan that gives a result ends while an earlier result is still held
// and not taken. A result passes through the input register and then the
// output register. Configuration writes are taken in every cycle and must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
module lidar_bump_and_go_controller #(
  parameter int unsigned MAX_SAMPLES = lbg_pkg::MAX_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lbg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbg_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [lbg_pkg::RANGE_W-1:0]     in_range_mm,
  input  logic                            in_range_finite,
  input  logic                            in_last_sample,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lbg_pkg::CODE_W-1:0]      out_motion,
  output logic [lbg_pkg::CODE_W-1:0]      out_mode,
  output logic [lbg_pkg::RANGE_W-1:0]     out_front_min_mm
);

  import lbg_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned CMP_W = (IDX_W > FRONT_IDX_W) ? IDX_W : FRONT_IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

  typedef enum logic [CODE_W-1:0] {
    MODE_DRIVING = 2'd0,
    MODE_BACKING = 2'd1,
    MODE_TURNING = 2'd2
  } mode_t;

  // configuration registers
  logic [RANGE_W-1:0]     obstacle_dist_r;
  logic [FRONT_IDX_W-1:0] front_first_r;
  logic [FRONT_IDX_W-1:0] front_last_r;
  logic [RANGE_W-1:0]     valid_lo_r;
  logic [RANGE_W-1:0]     valid_hi_r;
  logic [TICK_W-1:0]      backing_ticks_r;
  logic [TICK_W-1:0]      turning_ticks_r;

  // input register
  logic               s1_valid_r;
  logic               s1_cmd_r;
  logic [RANGE_W-1:0] s1_range_r;
  logic               s1_finite_r;
  logic               s1_last_r;

  // scan accumulators and mode machine
  logic [IDX_W-1:0]   sample_index_r, sample_index_nxt;
  logic               min_found_r, min_found_nxt;
  logic [RANGE_W-1:0] running_min_r, running_min_nxt;
  mode_t              mode_r, mode_nxt;
  logic [TICK_W-1:0]  elapsed_r, elapsed_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]  out_motion_r, out_motion_nxt;
  logic [CODE_W-1:0]  out_mode_r, out_mode_nxt;
  logic [RANGE_W-1:0] out_min_r, out_min_nxt;

  // datapath of the held request
  logic               is_sample;
  logic               is_tick;
  logic               in_window;
  logic               range_ok;
  logic               take;
  logic [RANGE_W-1:0] scan_min;
  logic               scan_found;
  logic               emit;
  logic               s1_advance;
  mode_t              step_mode;
  motion_t            step_motion;
  logic               step_clear;

  assign cfg_ready = 1'b1;

  assign is_sample = s1_valid_r && (s1_cmd_r == CMD_SAMPLE);
  assign is_tick   = s1_valid_r && (s1_cmd_r == CMD_TICK);

  // window check on the index this sample has in its scan; reversed window holds nothing
  assign in_window = (CMP_W'(sample_index_r) >= CMP_W'(front_first_r)) &&
                     (CMP_W'(sample_index_r) <= CMP_W'(front_last_r));
  assign range_ok  = s1_finite_r && (s1_range_r >= valid_lo_r) &&
                     (s1_range_r <= valid_hi_r);
  assign take      = in_window && range_ok &&
                     (!min_found_r || (s1_range_r < running_min_r));

  assign scan_min   = take ? s1_range_r : running_min_r;
  assign scan_found = min_found_r || take;

  // a result leaves only at the end of a scan that saw a valid front range
  assign emit       = is_sample && s1_last_r && scan_found;
  assign s1_advance = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  // one step of the drive / back-up / turn machine
  always_comb begin
    step_mode   = MODE_DRIVING;
    step_motion = MOVE_FORWARD;
    step_clear  = 1'b0;
    unique case (mode_r)
      MODE_BACKING: begin
        if (elapsed_r >= backing_ticks_r) begin
          step_mode   = MODE_TURNING;
          step_motion = MOVE_TURN;
          step_clear  = 1'b1;
        end else begin
          step_mode   = MODE_BACKING;
          step_motion = MOVE_REVERSE;
        end
      end
      MODE_TURNING: begin
        if (elapsed_r >= turning_ticks_r) begin
          step_mode   = MODE_DRIVING;
          step_motion = MOVE_FORWARD;
          step_clear  = 1'b1;
        end else begin
          step_mode   = MODE_TURNING;
          step_motion = MOVE_TURN;
        end
      end
      default: begin
        // driving, and the unused code taken as driving
        if (scan_min < obstacle_dist_r) begin
          step_mode   = MODE_BACKING;
          step_motion = MOVE_REVERSE;
          step_clear  = 1'b1;
        end else begin
          step_mode   = MODE_DRIVING;
          step_motion = MOVE_FORWARD;
        end
      end
    endcase
  end

  // next state of accumulators, mode and output register
  always_comb begin
    sample_index_nxt = sample_index_r;
    min_found_nxt    = min_found_r;
    running_min_nxt  = running_min_r;
    mode_nxt         = mode_r;
    elapsed_nxt      = elapsed_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_motion_nxt   = out_motion_r;
    out_mode_nxt     = out_mode_r;
    out_min_nxt      = out_min_r;

    if (s1_advance && is_tick) begin
      // saturating tick count
      if (elapsed_r != TICK_SAT) begin
        elapsed_nxt = elapsed_r + TICK_W'(1);
      end
    end

    if (s1_advance && is_sample) begin
      running_min_nxt = scan_min;
      min_found_nxt   = scan_found;
      // over-long scans pin the index at the last slot
      if (sample_index_r < IDX_LAST) begin
        sample_index_nxt = sample_index_r + IDX_W'(1);
      end
      if (s1_last_r) begin
        sample_index_nxt = '0;
        running_min_nxt  = '0;
        min_found_nxt    = 1'b0;
      end
      if (emit) begin
        mode_nxt       = step_mode;
        if (step_clear) begin
          elapsed_nxt = '0;
        end
        out_valid_nxt  = 1'b1;
        out_motion_nxt = step_motion;
        out_mode_nxt   = step_mode;
        out_min_nxt    = scan_min;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_dist_r <= OBSTACLE_DIST_RST;
      front_first_r   <= FRONT_FIRST_RST;
      front_last_r    <= FRONT_LAST_RST;
      valid_lo_r      <= RANGE_MIN_RST;
      valid_hi_r      <= RANGE_MAX_RST;
      backing_ticks_r <= BACKING_TICKS_RST;
      turning_ticks_r <= TURNING_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OBSTACLE_DIST: obstacle_dist_r <= cfg_data;
        CFG_FRONT_FIRST:   front_first_r   <= cfg_data[FRONT_IDX_W-1:0];
        CFG_FRONT_LAST:    front_last_r    <= cfg_data[FRONT_IDX_W-1:0];
        CFG_RANGE_MIN:     valid_lo_r      <= cfg_data;
        CFG_RANGE_MAX:     valid_hi_r      <= cfg_data;
        CFG_BACKING_TICKS: backing_ticks_r <= cfg_data;
        CFG_TURNING_TICKS: turning_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: loads whenever the held request moves on or it is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r    <= in_cmd;
      s1_range_r  <= in_range_mm;
      s1_finite_r <= in_range_finite;
      s1_last_r   <= in_last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      min_found_r    <= 1'b0;
      running_min_r  <= '0;
      mode_r         <= MODE_DRIVING;
      elapsed_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      sample_index_r <= sample_index_nxt;
      min_found_r    <= min_found_nxt;
      running_min_r  <= running_min_nxt;
      mode_r         <= mode_nxt;
      elapsed_r      <= elapsed_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_motion_r <= out_motion_nxt;
    out_mode_r   <= out_mode_nxt;
    out_min_r    <= out_min_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_motion       = out_motion_r;
  assign out_mode         = out_mode_r;
  assign out_front_min_mm = out_min_r;

  // motion code always agrees with the mode entered by the step
  a_motion_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_motion_r == out_mode_r))
    else $error("motion code disagrees with mode");

  // ticks never disturb the scan accumulators
  a_tick_keeps_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && is_tick) |=> ($stable(sample_index_r) && $stable(min_found_r) &&
                                 $stable(running_min_r)))
    else $error("tick changed scan state");

  // end of scan clears the accumulators
  a_scan_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && is_sample && s1_last_r) |=>
      ((sample_index_r == '0) && !min_found_r && (running_min_r == '0)))
    else $error("scan accumulators not cleared at end of scan");

  // stall only when a request is held and its result cannot be placed
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && emit && out_valid_r && !out_ready))
    else $error("input stalled without cause");

endmodule
